// File: rtl/pms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pms_pkg;

    localparam int NUM_STACKS_DEF  = 3;
    localparam int STACK_DEPTH_DEF = 8;

    localparam int FUNC_W   = 2;
    localparam int SID_W    = 2;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

    localparam logic signed [DATA_W-1:0] NO_DATA = -32'sd999;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_cmd;

endpackage

`default_nettype wire

// File: rtl/pms_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module pms_mem
    import pms_pkg::*;
#(
    parameter int DEPTH = NUM_STACKS_DEF * STACK_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                     i_clk,
    input  wire t_mem_cmd                 i_cmd,
    input  wire logic [AW-1:0]            i_addr,
    input  wire logic signed [DATA_W-1:0] i_wdata,
    output logic signed [DATA_W-1:0]      o_rdata
);

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/pms_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pms_ctrl
    import pms_pkg::*;
#(
    parameter int NUM_STACKS  = NUM_STACKS_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int AW          = $clog2(NUM_STACKS * STACK_DEPTH)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic                 i_out_take,
    input  wire logic [FUNC_W-1:0]    i_func,
    input  wire logic [SID_W-1:0]     i_stack_id,
    output t_mem_cmd                  o_cmd,
    output logic [AW-1:0]             o_addr,
    output logic                      o_out_valid,
    output logic [STATUS_W-1:0]       o_status,
    output logic                      o_peek_ok,
    output logic                      o_now_empty,
    output logic                      o_now_full
);

    localparam int SIW = $clog2(NUM_STACKS);
    localparam int CW  = $clog2(STACK_DEPTH + 1);

    logic [CW-1:0]       r_count [NUM_STACKS];
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic                r_peek_ok;
    logic                r_empty;
    logic                r_full;

    logic                sid_ok;
    logic [SIW-1:0]      sid_idx;
    logic [CW-1:0]       cnt;
    logic [CW-1:0]       n_cnt;
    logic                is_push;
    logic                is_pop;
    logic                cnt_full;
    logic                cnt_empty;
    logic [STATUS_W-1:0] n_status;
    logic                n_peek_ok;
    logic [AW-1:0]       base;

    always_comb begin
        sid_ok    = {{(32-SID_W){1'b0}}, i_stack_id} < NUM_STACKS;
        sid_idx   = i_stack_id[SIW-1:0];
        cnt       = sid_ok ? r_count[sid_idx] : '0;
        is_push   = i_func == FUNC_PUSH;
        is_pop    = i_func == FUNC_POP;
        cnt_full  = cnt == CW'(STACK_DEPTH);
        cnt_empty = cnt == '0;
        n_cnt     = cnt;
        n_status  = ST_OK;
        n_peek_ok = 1'b0;
        if (!sid_ok) begin
            n_status = ST_INVALID;
        end else if (is_push) begin
            if (cnt_full) begin
                n_status = ST_FULL;
            end else begin
                n_cnt = cnt + CW'(1);
            end
        end else if (cnt_empty) begin
            n_status = ST_EMPTY;
        end else if (is_pop) begin
            n_cnt = cnt - CW'(1);
        end else begin
            n_peek_ok = 1'b1;
        end
        base         = AW'(sid_idx) * AW'(STACK_DEPTH);
        o_addr       = base + AW'(cnt) - (is_push ? AW'(0) : AW'(1));
        o_cmd.wr_en  = i_accept && sid_ok && is_push && !cnt_full;
        o_cmd.rd_en  = i_accept && n_peek_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_STACKS; k++) begin
                r_count[k] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                if (sid_ok) begin
                    r_count[sid_idx] <= n_cnt;
                end
                r_out_valid <= 1'b1;
            end else if (i_out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_status  <= n_status;
            r_peek_ok <= n_peek_ok;
            r_empty   <= sid_ok && (n_cnt == '0);
            r_full    <= sid_ok && (n_cnt == CW'(STACK_DEPTH));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_peek_ok   = r_peek_ok;
    assign o_now_empty = r_empty;
    assign o_now_full  = r_full;

endmodule

`default_nettype wire

// File: rtl/partitioned_multi_stack.sv
`timescale 1ns / 1ps
`default_nettype none

// NUM_STACKS independent stacks of STACK_DEPTH words share one synchronous memory;
// stack s owns words s*STACK_DEPTH up to s*STACK_DEPTH+STACK_DEPTH-1. Each transfer
// asks for push (0), pop (1) or peek (2 or 3) and yields one result transfer with a
// status (0 ok, 1 bad stack number, 2 full, 3 empty), the peeked word (else -999)
// and the stack's empty and full flags after the operation. Stack counts sit in
// registers and are updated at acceptance, so one transfer is taken every cycle
// unless the output is stalled; the result appears in the cycle after acceptance.
// The memory needs no clearing after reset: only pushed words are ever read.

module partitioned_multi_stack
    import pms_pkg::*;
#(
    parameter int NUM_STACKS  = NUM_STACKS_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [FUNC_W-1:0]        i_func,
    input  wire logic [SID_W-1:0]         i_stack_id,
    input  wire logic signed [DATA_W-1:0] i_item,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [STATUS_W-1:0]           o_status,
    output logic signed [DATA_W-1:0]      o_data,
    output logic                          o_now_empty,
    output logic                          o_now_full
);

    localparam int DEPTH = NUM_STACKS * STACK_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    t_mem_cmd                 mem_cmd;
    logic [AW-1:0]            mem_addr;
    logic signed [DATA_W-1:0] mem_rdata;
    logic                     accept;
    logic                     peek_ok;

    assign o_in_stall = o_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    pms_ctrl #(
        .NUM_STACKS  (NUM_STACKS),
        .STACK_DEPTH (STACK_DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_out_take  (!i_out_stall),
        .i_func      (i_func),
        .i_stack_id  (i_stack_id),
        .o_cmd       (mem_cmd),
        .o_addr      (mem_addr),
        .o_out_valid (o_out_valid),
        .o_status    (o_status),
        .o_peek_ok   (peek_ok),
        .o_now_empty (o_now_empty),
        .o_now_full  (o_now_full)
    );

    pms_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_cmd   (mem_cmd),
        .i_addr  (mem_addr),
        .i_wdata (i_item),
        .o_rdata (mem_rdata)
    );

    assign o_data = peek_ok ? mem_rdata : NO_DATA;

endmodule

`default_nettype wire
